[src/scatr_pkg.sv]
// shared types, codes and factor tables of the answer-to-reset byte parser
// no dependencies
package scatr_pkg;

  localparam logic [2:0] PH_TS    = 3'd0;
  localparam logic [2:0] PH_T0    = 3'd1;
  localparam logic [2:0] PH_IFACE = 3'd2;
  localparam logic [2:0] PH_HIST  = 3'd3;
  localparam logic [2:0] PH_TCK   = 3'd4;
  localparam logic [2:0] PH_GARB  = 3'd5;

  localparam logic [3:0] KIND_TS   = 4'd0;
  localparam logic [3:0] KIND_T0   = 4'd1;
  localparam logic [3:0] KIND_TA   = 4'd2;
  localparam logic [3:0] KIND_TB   = 4'd3;
  localparam logic [3:0] KIND_TC   = 4'd4;
  localparam logic [3:0] KIND_TD   = 4'd5;
  localparam logic [3:0] KIND_HIST = 4'd6;
  localparam logic [3:0] KIND_TCK  = 4'd7;
  localparam logic [3:0] KIND_GARB = 4'd8;

  localparam logic [1:0] CONV_DIRECT  = 2'd0;
  localparam logic [1:0] CONV_INVERSE = 2'd1;
  localparam logic [1:0] CONV_INVALID = 2'd2;

  localparam logic [1:0] CKS_NONE    = 2'd0;
  localparam logic [1:0] CKS_GOOD    = 2'd1;
  localparam logic [1:0] CKS_BAD     = 2'd2;
  localparam logic [1:0] CKS_MISSING = 2'd3;

  localparam logic [7:0] TS_DIRECT  = 8'h3b;
  localparam logic [7:0] TS_INVERSE = 8'h3f;
  localparam logic [7:0] TA2_RSV    = 8'h60;

  localparam int OUT_BITS = 64;

  typedef struct packed {
    logic [2:0] phase;
    logic [3:0] pending;
    logic [3:0] grp;
    logic [3:0] hist;
    logic [7:0] xor_v;
    logic [7:0] chk_val;
    logic       chk_seen;
    logic [7:0] garb;
  } atr_state_t;

  localparam atr_state_t ST_RESET = '{
    phase: PH_TS, pending: 4'd0, grp: 4'd0, hist: 4'd0,
    xor_v: 8'd0, chk_val: 8'd0, chk_seen: 1'b0, garb: 8'd0
  };

  typedef struct packed {
    logic [7:0]         garbage_total;
    logic [7:0]         computed_checksum;
    logic [1:0]         checksum_status;
    logic               length_error;
    logic [1:0]         convention;
    logic               reserved_note;
    logic signed [6:0]  rate_factor;
    logic signed [12:0] clock_factor;
    logic [3:0]         protocol_type;
    logic [7:0]         byte_echo;
    logic [3:0]         group_number;
    logic [3:0]         byte_kind;
  } atr_result_t;

  function automatic logic signed [12:0] f_lookup(input logic [3:0] code);
    logic signed [12:0] f;
    case (code)
      4'd0:    f = 13'sd0;
      4'd1:    f = 13'sd372;
      4'd2:    f = 13'sd558;
      4'd3:    f = 13'sd744;
      4'd4:    f = 13'sd1116;
      4'd5:    f = 13'sd1488;
      4'd6:    f = 13'sd1860;
      4'd9:    f = 13'sd512;
      4'd10:   f = 13'sd768;
      4'd11:   f = 13'sd1024;
      4'd12:   f = 13'sd1536;
      4'd13:   f = 13'sd2048;
      default: f = -13'sd1;
    endcase
    return f;
  endfunction

  function automatic logic signed [6:0] d_lookup(input logic [3:0] code);
    logic signed [6:0] d;
    case (code)
      4'd1:    d = 7'sd1;
      4'd2:    d = 7'sd2;
      4'd3:    d = 7'sd4;
      4'd4:    d = 7'sd8;
      4'd5:    d = 7'sd16;
      4'd8:    d = 7'sd0;
      4'd10:   d = -7'sd2;
      4'd11:   d = -7'sd4;
      4'd12:   d = -7'sd8;
      4'd13:   d = -7'sd16;
      4'd14:   d = -7'sd32;
      4'd15:   d = -7'sd64;
      default: d = -7'sd1;
    endcase
    return d;
  endfunction

endpackage

[src/scatr_decode.sv]
// per-byte classification and parser next-state logic
// depends on scatr_pkg
module scatr_decode
  import scatr_pkg::*;
(
  input  atr_state_t  st,
  input  logic [7:0]  atr_byte,
  input  logic        last_byte,
  output atr_state_t  st_nxt,
  output atr_result_t res
);

  atr_state_t  nx;
  logic [3:0]  hist_dec;

  function automatic logic [2:0] after_group(input logic [3:0] pend, input logic [3:0] hist);
    logic [2:0] ph;
    if (pend != 4'd0) ph = PH_IFACE;
    else if (hist != 4'd0) ph = PH_HIST;
    else ph = PH_TCK;
    return ph;
  endfunction

  assign hist_dec = (st.hist != 4'd0) ? st.hist - 4'd1 : 4'd0;

  always_comb begin
    nx  = st;
    res = '0;
    res.byte_echo = atr_byte;
    res.byte_kind = KIND_GARB;
    case (st.phase)
      PH_TS: begin
        res.byte_kind = KIND_TS;
        if (atr_byte == TS_DIRECT) res.convention = CONV_DIRECT;
        else if (atr_byte == TS_INVERSE) res.convention = CONV_INVERSE;
        else res.convention = CONV_INVALID;
        nx.phase = PH_T0;
      end
      PH_T0: begin
        res.byte_kind = KIND_T0;
        nx.pending = atr_byte[7:4];
        nx.hist    = atr_byte[3:0];
        nx.grp     = 4'd1;
        nx.phase   = after_group(atr_byte[7:4], atr_byte[3:0]);
      end
      PH_IFACE: begin
        res.group_number = st.grp;
        if (st.pending[0]) begin
          res.byte_kind = KIND_TA;
          nx.pending = st.pending & 4'he;
          if (st.grp == 4'd1) begin
            res.clock_factor  = f_lookup(atr_byte[7:4]);
            res.rate_factor   = d_lookup(atr_byte[3:0]);
            res.reserved_note = (res.clock_factor == -13'sd1) || (res.rate_factor == -7'sd1);
          end else if (st.grp == 4'd2) begin
            res.reserved_note = |(atr_byte & TA2_RSV);
          end
        end else if (st.pending[1]) begin
          res.byte_kind = KIND_TB;
          nx.pending = st.pending & 4'hc;
          if (st.grp == 4'd1) res.reserved_note = atr_byte[7];
        end else if (st.pending[2]) begin
          res.byte_kind = KIND_TC;
          nx.pending = st.pending & 4'h8;
        end else begin
          res.byte_kind     = KIND_TD;
          res.protocol_type = atr_byte[3:0];
          nx.pending        = atr_byte[7:4];
          if (st.grp != 4'd15) nx.grp = st.grp + 4'd1;
        end
        nx.phase = after_group(nx.pending, st.hist);
      end
      PH_HIST: begin
        res.byte_kind = KIND_HIST;
        nx.hist  = hist_dec;
        nx.phase = (hist_dec != 4'd0) ? PH_HIST : PH_TCK;
      end
      PH_TCK: begin
        res.byte_kind = KIND_TCK;
        nx.chk_val  = atr_byte;
        nx.chk_seen = 1'b1;
        nx.phase    = PH_GARB;
      end
      default: begin
        res.byte_kind = KIND_GARB;
        if (st.garb != 8'hff) nx.garb = st.garb + 8'd1;
      end
    endcase

    if (res.byte_kind != KIND_TS) nx.xor_v = st.xor_v ^ atr_byte;

    if (last_byte) begin
      res.length_error      = !nx.chk_seen;
      res.computed_checksum = st.xor_v;
      res.garbage_total     = nx.garb;
      if (!nx.chk_seen) res.checksum_status = CKS_MISSING;
      else if (nx.chk_val == st.xor_v) res.checksum_status = CKS_GOOD;
      else res.checksum_status = CKS_BAD;
      st_nxt = ST_RESET;
    end else begin
      st_nxt = nx;
    end
  end

endmodule

[src/smart_card_atr_parser_unit.sv]
// path: an accepted request is held in the input register, then decoded into the result register that drives out_tvalid
// throughput: one byte per cycle while out_tready is high; parser state updates as a byte leaves the input register
// stalls: a waiting result holds; the input register takes one more request, then in_tready drops
// reset: rst_n low clears both valid flags and returns the parser to waiting for ts
// top level of the answer-to-reset byte parser: input register, decode, result register
// depends on scatr_pkg and scatr_decode
module smart_card_atr_parser_unit
  import scatr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // atr_byte
  input  logic                in_tlast,   // last_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [3:0]          out_tuser,  // byte_kind
  // group_number, byte_echo, protocol_type, clock_factor, rate_factor,
  // reserved_note, convention, length_error, checksum_status, computed_checksum,
  // garbage_total, zero pad
  output logic [OUT_BITS-1:0] out_tdata
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  atr_result_t out_res_r;
  atr_state_t  st_r;
  atr_state_t  st_nxt;
  atr_result_t res;
  logic        s1_advance;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  scatr_decode u_decode (
    .st        (st_r),
    .atr_byte  (s1_byte_r),
    .last_byte (s1_last_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ST_RESET;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_advance) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.byte_kind;
  assign out_tdata  = {{(OUT_BITS - $bits(atr_result_t) + 4){1'b0}},
                       out_res_r[$bits(atr_result_t)-1:4]};

  // a final byte always hands the parser back to waiting for ts
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && s1_last_r |=> st_r.phase == PH_TS && !st_r.chk_seen && st_r.garb == 8'd0)
    else $error("parser state not cleared after final byte");

  // interface phase only with an interface byte still announced
  a_iface_pending: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_IFACE |-> st_r.pending != 4'd0)
    else $error("interface phase with no pending byte");

  // historical phase only with historical bytes left
  a_hist_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_HIST |-> st_r.hist != 4'd0)
    else $error("historical phase with zero count");

  // verdict fields only on a final byte
  a_verdict_final: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && !s1_last_r |=> out_res_r.checksum_status == CKS_NONE
      && !out_res_r.length_error && out_res_r.garbage_total == 8'd0)
    else $error("verdict reported on non-final byte");

  // checksum captured at most once per run: it is seen only in the garbage phase
  a_tck_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.chk_seen |-> st_r.phase == PH_GARB)
    else $error("checksum seen outside garbage phase");

endmodule
